@@ hw/rtl/quicksort_engine_top_assert.svh @@
// Assertion macros used by the quicksort engine checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef QUICKSORT_ENGINE_TOP_ASSERT_SVH
`define QUICKSORT_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define QSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define QSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/qse_pkg.sv @@
// Shared types and sizes of the quicksort engine.
// No dependencies; used by qse_cmp, quicksort_engine_top and qse_checker.
package qse_pkg;

    localparam int DATA_W      = 32;
    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STACK_SLOTS = 7;
    localparam int SP_W        = $clog2(STACK_SLOTS + 1);
    localparam int SLOT_W      = $clog2(STACK_SLOTS);

    // Result of the shared signed compare
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

    // Sequencer states, one-hot
    typedef enum logic [14:0] {
        S_LOAD   = 15'b000000000000001,
        S_INIT   = 15'b000000000000010,
        S_PIV_RD = 15'b000000000000100,
        S_PIV    = 15'b000000000001000,
        S_I_RD   = 15'b000000000010000,
        S_I_CMP  = 15'b000000000100000,
        S_J_RD   = 15'b000000001000000,
        S_J_CMP  = 15'b000000010000000,
        S_CHECK  = 15'b000000100000000,
        S_SWAP_J = 15'b000001000000000,
        S_FIN    = 15'b000010000000000,
        S_POP    = 15'b000100000000000,
        S_E_RD   = 15'b001000000000000,
        S_E_LOAD = 15'b010000000000000,
        S_E_WAIT = 15'b100000000000000
    } state_t;

endpackage

@@ hw/rtl/qse_cmp.sv @@
// Shared signed comparator of the quicksort engine.
// Depends on qse_pkg for the data width and the result struct.
module qse_cmp
    import qse_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output cmp_res_t                 res
);

    logic [DATA_W:0] diff;
    logic            eq;

    // One subtract gives less-than; equal plus less-than gives greater-than
    assign diff   = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    assign eq     = (a == b);
    assign res.lt = diff[DATA_W];
    assign res.gt = !diff[DATA_W] && !eq;

endmodule

@@ hw/rtl/quicksort_engine_top.sv @@
// Quicksort engine top level: element store, range stack and sequencer.
// Depends on qse_pkg and qse_cmp.
//
// Usage:
//   Input channel (item_valid/item_ready) takes one signed 32-bit word per
//   cycle into the element store. The word flagged last_element closes the
//   set and starts the sort. Words beyond 64 are dropped and overflow is
//   raised on every result of that set.
//   Output channel (result_valid/result_ready) delivers the set ascending,
//   one word per handshake, last_out on the final word.
//   Sorting: the sort is bound by the element store, which has a single
//   write and a single registered read port: each partition scans one
//   element per cycle, each swap writes both words (S_CHECK, S_SWAP_J)
//   and restarts both scans through S_I_RD and S_J_RD, and each range
//   passes S_PIV_RD, S_PIV and S_FIN, and S_POP when popped from the stack.
//   Each result passes S_E_RD, S_E_LOAD and S_E_WAIT, where it waits for
//   any receiver stall.
//   item_ready is low from the last word until the last result is taken.
//   A stalled receiver holds the result word steady; the sequencer waits.
//   Reset empties the store (count zero, no overflow) and needs no sweep.
module quicksort_engine_top
    import qse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last_element,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_out_reg, last_out_next;

    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic signed [DATA_W-1:0] vi_reg, vi_next;
    logic signed [DATA_W-1:0] vj_reg, vj_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;

    // Element store, single write and single registered read port
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [IDX_W-1:0]         mem_raddr;

    // Range stack
    logic [IDX_W-1:0]  stack_lo_reg [STACK_SLOTS];
    logic [IDX_W-1:0]  stack_hi_reg [STACK_SLOTS];
    logic              stack_we;
    logic [IDX_W-1:0]  stack_wlo;
    logic [IDX_W-1:0]  stack_whi;
    logic [SLOT_W-1:0] push_slot;
    logic [SLOT_W-1:0] top_slot;
    logic [SP_W-1:0]   sp_m1;

    cmp_res_t         cmp;
    logic             in_fire;
    logic             out_fire;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] k_p1;
    logic [IDX_W-1:0] p;
    logic [CNT_W-1:0] p_p1;
    logic [CNT_W-1:0] lo_p1;
    logic [IDX_W-1:0] left_len;
    logic [IDX_W-1:0] right_len;
    logic [CNT_W-1:0] j_m1;

    qse_cmp u_cmp (
        .a   (rd_data_reg),
        .b   (pivot_reg),
        .res (cmp)
    );

    assign in_fire   = item_valid && item_ready;
    assign out_fire  = out_valid_reg && result_ready;
    assign count_m1  = count_reg - CNT_W'(1);
    assign k_p1      = {1'b0, k_reg} + CNT_W'(1);
    assign p         = j_reg[IDX_W-1:0];
    assign p_p1      = {1'b0, p} + CNT_W'(1);
    assign lo_p1     = {1'b0, lo_reg} + CNT_W'(1);
    assign left_len  = p - lo_reg;
    assign right_len = hi_reg - p;
    assign j_m1      = j_reg - CNT_W'(1);
    assign sp_m1     = sp_reg - SP_W'(1);
    assign push_slot = sp_reg[SLOT_W-1:0];
    assign top_slot  = sp_m1[SLOT_W-1:0];

    assign item_ready   = (state_reg == S_LOAD);
    assign result_valid = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_out     = last_out_reg;
    assign overflow     = ovf_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        last_out_next  = last_out_reg;
        pivot_next     = pivot_reg;
        vi_next        = vi_reg;
        vj_next        = vj_reg;
        out_value_next = out_value_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        stack_we       = 1'b0;
        stack_wlo      = '0;
        stack_whi      = '0;

        case (state_reg)
            S_LOAD:
            begin
                // Store the word, or drop it when the store is full
                if (in_fire)
                begin
                    if (count_reg < CNT_W'(DEPTH))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_element)
                    begin
                        state_next = S_INIT;
                    end
                end
            end

            S_INIT:
            begin
                k_next = '0;
                if (count_reg < CNT_W'(2))
                begin
                    state_next = S_E_RD;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_m1[IDX_W-1:0];
                    state_next = S_PIV_RD;
                end
            end

            S_PIV_RD:
            begin
                mem_raddr  = lo_reg;
                state_next = S_PIV;
            end

            S_PIV:
            begin
                // Latch pivot, start both scans
                pivot_next = rd_data_reg;
                i_next     = lo_reg;
                j_next     = {1'b0, hi_reg} + CNT_W'(1);
                state_next = S_I_RD;
            end

            S_I_RD:
            begin
                i_next     = i_reg + IDX_W'(1);
                mem_raddr  = i_reg + IDX_W'(1);
                state_next = S_I_CMP;
            end

            S_I_CMP:
            begin
                // Advance left scan while element is below pivot
                vi_next = rd_data_reg;
                if (!cmp.lt || (i_reg == hi_reg))
                begin
                    state_next = S_J_RD;
                end
                else
                begin
                    i_next    = i_reg + IDX_W'(1);
                    mem_raddr = i_reg + IDX_W'(1);
                end
            end

            S_J_RD:
            begin
                j_next     = j_m1;
                mem_raddr  = j_m1[IDX_W-1:0];
                state_next = S_J_CMP;
            end

            S_J_CMP:
            begin
                // Advance right scan while element is above pivot
                vj_next = rd_data_reg;
                if (!cmp.gt || (j_reg == {1'b0, lo_reg}))
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    j_next    = j_m1;
                    mem_raddr = j_m1[IDX_W-1:0];
                end
            end

            S_CHECK:
            begin
                mem_we = 1'b1;
                if ({1'b0, i_reg} >= j_reg)
                begin
                    // Scans crossed: move element at j to the range start
                    mem_waddr  = lo_reg;
                    mem_wdata  = vj_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    mem_waddr  = i_reg;
                    mem_wdata  = vj_reg;
                    state_next = S_SWAP_J;
                end
            end

            S_SWAP_J:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p;
                mem_wdata  = vi_reg;
                state_next = S_I_RD;
            end

            S_FIN:
            begin
                // Drop pivot into place, push larger side if room, keep smaller
                mem_we    = 1'b1;
                mem_waddr = p;
                mem_wdata = pivot_reg;
                if (left_len < right_len)
                begin
                    if ((p_p1 < {1'b0, hi_reg}) && (sp_reg < SP_W'(STACK_SLOTS)))
                    begin
                        stack_we  = 1'b1;
                        stack_wlo = p + IDX_W'(1);
                        stack_whi = hi_reg;
                        sp_next   = sp_reg + SP_W'(1);
                    end
                    hi_next = p - IDX_W'(1);
                    if ((p != lo_reg) && (lo_p1 < {1'b0, p}))
                    begin
                        state_next = S_PIV_RD;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else
                begin
                    if ((lo_p1 < {1'b0, p}) && (sp_reg < SP_W'(STACK_SLOTS)))
                    begin
                        stack_we  = 1'b1;
                        stack_wlo = lo_reg;
                        stack_whi = p - IDX_W'(1);
                        sp_next   = sp_reg + SP_W'(1);
                    end
                    lo_next = p + IDX_W'(1);
                    if (p_p1 < {1'b0, hi_reg})
                    begin
                        state_next = S_PIV_RD;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end

            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_E_RD;
                end
                else
                begin
                    sp_next    = sp_m1;
                    lo_next    = stack_lo_reg[top_slot];
                    hi_next    = stack_hi_reg[top_slot];
                    state_next = S_PIV_RD;
                end
            end

            S_E_RD:
            begin
                mem_raddr  = k_reg;
                state_next = S_E_LOAD;
            end

            S_E_LOAD:
            begin
                out_value_next = rd_data_reg;
                last_out_next  = (k_p1 == count_reg);
                out_valid_next = 1'b1;
                state_next     = S_E_WAIT;
            end

            S_E_WAIT:
            begin
                // Hold the word until the receiver takes it
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (last_out_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sp_next    = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_E_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        last_out_reg  <= last_out_next;
        pivot_reg     <= pivot_next;
        vi_reg        <= vi_next;
        vj_reg        <= vj_next;
        out_value_reg <= out_value_next;
    end

    // Element store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Range stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_lo_reg[push_slot] <= stack_wlo;
            stack_hi_reg[push_slot] <= stack_whi;
        end
    end

endmodule

@@ hw/rtl/qse_checker.sv @@
// Port-level checker for the quicksort engine, bound to the top level.
// Depends on qse_pkg and quicksort_engine_top_assert.svh.
`include "quicksort_engine_top_assert.svh"

module qse_checker
    import qse_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_ready,
    input logic                     last_element,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic signed [DATA_W-1:0] sorted_value,
    input logic                     last_out,
    input logic                     overflow
);

    // Stalled result word holds
    `QSE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(sorted_value) && $stable(last_out),
        "result word changed while stalled")

    // No word is taken while results are pending
    `QSE_ASSERT_NOW(a_no_load_in_emit, result_valid, !item_ready,
        "input taken while a result is pending")

    // Last word closes the input until the run is out
    `QSE_ASSERT_NEXT(a_close_on_last, item_valid && item_ready && last_element, !item_ready,
        "input still open after last word")

    // Run end drops the output channel
    `QSE_ASSERT_NEXT(a_run_end, result_valid && result_ready && last_out, !result_valid,
        "result still valid after end of run")

    // Overflow stays steady across a run
    `QSE_ASSERT_NEXT(a_ovf_steady, result_valid && result_ready && !last_out,
        $stable(overflow), "overflow changed within a run")

endmodule

bind quicksort_engine_top qse_checker u_qse_checker (.*);
